// File: src/jtag_memory_block_access_framer_top_defines.svh
// ----------------------------------------------------------------------------
// jtag_memory_block_access_framer_top_defines.svh
// Assertion macros shared by the framer checker.
// ----------------------------------------------------------------------------
`ifndef JTAG_MEMORY_BLOCK_ACCESS_FRAMER_TOP_DEFINES_SVH
`define JTAG_MEMORY_BLOCK_ACCESS_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JMBAF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JMBAF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/jmbaf_pkg.sv
// ----------------------------------------------------------------------------
// jmbaf_pkg
// Types, codes and helper functions of the memory block scan framer.
// ----------------------------------------------------------------------------
package jmbaf_pkg;

  localparam int BLOCK_COUNT = 4;
  localparam int BLK_IDX_W   = 2;

  localparam logic [2:0] CFG_DATA_BASE = 3'd4;

  typedef enum logic [1:0] {
    OP_READ_START = 2'd0,
    OP_READ_NEXT  = 2'd1,
    OP_READ_END   = 2'd2,
    OP_WRITE      = 2'd3
  } op_t;

  localparam logic [2:0] INSTR_IDLE  = 3'd0;
  localparam logic [2:0] INSTR_READ  = 3'd1;
  localparam logic [2:0] INSTR_WRITE = 3'd2;

  typedef struct packed {
    logic        valid;
    logic [4:0]  aw;
    logic [5:0]  dw;
    logic [1:0]  sh;
    logic [31:0] start;
    logic [31:0] endp;
    logic [31:0] endp1;
  } blk_t;

  typedef blk_t map_t [BLOCK_COUNT];

  typedef struct packed {
    logic                 hit;
    logic [BLK_IDX_W-1:0] idx;
  } dec_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] bus_address;
    logic [31:0] write_value;
    logic [31:0] captured_bits;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic        shift_done;
    logic        capture_out;
    logic [2:0]  instr_field;
    logic [1:0]  block_field;
    logic [23:0] address_field;
    logic [31:0] data_field;
    logic [31:0] read_value;
  } res_t;

  function automatic logic [23:0] addr_mask(input logic [4:0] aw);
    logic [24:0] m;
    begin
      m = (25'(1) << aw) - 25'(1);
      addr_mask = (aw >= 5'd24) ? 24'hFF_FFFF : m[23:0];
    end
  endfunction

  function automatic logic [31:0] data_mask(input logic [5:0] dw);
    logic [32:0] m;
    begin
      m = (33'(1) << dw) - 33'(1);
      data_mask = (dw >= 6'd32) ? 32'hFFFF_FFFF : m[31:0];
    end
  endfunction

endpackage

// File: src/jmbaf_map.sv
// ----------------------------------------------------------------------------
// jmbaf_map
// Configuration registers and the sequential address map builder.
// ----------------------------------------------------------------------------
module jmbaf_map import jmbaf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_data,
  output map_t       blk_map,
  output logic       busy
);

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_END1  = 3'b010,
    PH_END   = 3'b100
  } phase_t;

  logic [4:0]           cfg_aw [BLOCK_COUNT];
  logic [5:0]           cfg_dw [BLOCK_COUNT];
  phase_t               phase;
  logic [BLK_IDX_W-1:0] sel;
  logic                 prev_valid;
  logic [7:0]           prev_key;
  logic [31:0]          prior_base;
  logic [31:0]          prev_endp1;

  logic [4:0]  aw;
  logic [5:0]  dw;
  logic [6:0]  nbytes_sum;
  logic [3:0]  nbytes;
  logic [1:0]  sh;
  logic [5:0]  expo;
  logic [31:0] sz;
  logic [7:0]  key;
  logic        blk_ok;
  logic [31:0] start_next;

  always_comb begin
    aw         = cfg_aw[sel];
    dw         = cfg_dw[sel];
    nbytes_sum = {1'b0, dw} + 7'd7;
    nbytes     = nbytes_sum[6:3];
    if (nbytes >= 4'd8) begin
      sh = 2'd3;
    end else if (nbytes >= 4'd4) begin
      sh = 2'd2;
    end else if (nbytes >= 4'd2) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    expo   = {1'b0, aw} + {4'd0, sh};
    sz     = (expo >= 6'd32) ? 32'd0 : (32'd1 << expo[4:0]);
    key    = 8'({3'd0, aw} << sh);
    blk_ok = (aw != 5'd0) && (dw != 6'd0);
    if (!prev_valid) begin
      start_next = 32'd0;
    end else if (key <= prev_key) begin
      start_next = prev_endp1;
    end else begin
      start_next = (prior_base & ~(sz - 32'd1)) + sz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        cfg_aw[i]        <= 5'd0;
        cfg_dw[i]        <= 6'd0;
        blk_map[i].valid <= 1'b0;
      end
      busy       <= 1'b0;
      phase      <= PH_START;
      sel        <= '0;
      prev_valid <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index < CFG_DATA_BASE) begin
        cfg_aw[cfg_index[BLK_IDX_W-1:0]] <= cfg_data[4:0];
      end else begin
        cfg_dw[cfg_index[BLK_IDX_W-1:0]] <= cfg_data;
      end
      busy       <= 1'b1;
      phase      <= PH_START;
      sel        <= '0;
      prev_valid <= 1'b0;
    end else if (busy) begin
      case (phase)
        PH_START: begin
          blk_map[sel].valid <= blk_ok;
          blk_map[sel].aw    <= aw;
          blk_map[sel].dw    <= dw;
          blk_map[sel].sh    <= sh;
          blk_map[sel].start <= start_next;
          phase              <= PH_END1;
        end
        PH_END1: begin
          blk_map[sel].endp1 <= blk_map[sel].start + sz;
          phase              <= PH_END;
        end
        PH_END: begin
          blk_map[sel].endp <= blk_map[sel].endp1 - 32'd1;
          if (blk_ok) begin
            prev_valid <= 1'b1;
            prev_key   <= key;
            prior_base <= blk_map[sel].start;
            prev_endp1 <= blk_map[sel].endp1;
          end
          if (sel == BLK_IDX_W'(BLOCK_COUNT - 1)) begin
            busy <= 1'b0;
          end else begin
            sel <= sel + 1'b1;
          end
          phase <= PH_START;
        end
        default: begin
          phase <= PH_START;
        end
      endcase
    end
  end

endmodule

// File: src/jmbaf_decode.sv
// ----------------------------------------------------------------------------
// jmbaf_decode
// Address decode against the block map, highest block first.
// ----------------------------------------------------------------------------
module jmbaf_decode import jmbaf_pkg::*; (
  input  map_t        blk_map,
  input  logic [31:0] adr,
  output dec_t        dec
);

  logic [BLOCK_COUNT-1:0] in_rng;
  logic [BLOCK_COUNT-1:0] end_lt;
  logic [BLOCK_COUNT-1:0] st_gt;
  logic [BLOCK_COUNT-1:0] st_z;
  logic [BLOCK_COUNT-1:0] ep_gt;
  logic [BLOCK_COUNT-1:0] ep_z;

  // all wide compares in parallel
  always_comb begin
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      in_rng[i] = (blk_map[i].start <= adr) && (blk_map[i].endp >= adr);
      end_lt[i] = blk_map[i].endp < adr;
      st_gt[i]  = blk_map[i].start > adr;
      st_z[i]   = blk_map[i].start == 32'd0;
      ep_gt[i]  = blk_map[i].endp1 > adr;
      ep_z[i]   = blk_map[i].endp1 == 32'd0;
    end
  end

  // running bound kept as two flags: bound > adr, bound == 0
  always_comb begin
    logic bgt;
    logic bz;
    bgt     = 1'b0;
    bz      = 1'b1;
    dec.hit = 1'b0;
    dec.idx = '0;
    for (int i = BLOCK_COUNT - 1; i >= 0; i--) begin
      if (blk_map[i].valid) begin
        if (in_rng[i]) begin
          dec.hit = 1'b1;
          dec.idx = BLK_IDX_W'(i);
          bgt     = st_gt[i];
          bz      = st_z[i];
        end else if ((bgt || bz) && end_lt[i]) begin
          dec.hit = 1'b0;
          bgt     = ep_gt[i];
          bz      = ep_z[i];
        end else begin
          bgt = st_gt[i];
          bz  = st_z[i];
        end
      end
    end
  end

endmodule

// File: src/jmbaf_frame.sv
// ----------------------------------------------------------------------------
// jmbaf_frame
// Scan frame state and the per-transaction frame update.
// ----------------------------------------------------------------------------
module jmbaf_frame import jmbaf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  map_t  blk_map,
  output res_t  res
);

  logic [2:0]  frame_instr;
  logic [1:0]  frame_block;
  logic [23:0] frame_address;
  logic [31:0] frame_data;
  logic [31:0] previous_address;

  logic [2:0]  instr_next;
  logic [1:0]  block_next;
  logic [23:0] address_next;
  logic [31:0] data_next;
  logic [31:0] prev_next;

  logic [31:0] dec_adr;
  dec_t        dec;
  blk_t        blk;
  logic [23:0] am;
  logic [31:0] dm;
  logic [23:0] a_word;
  logic [23:0] addr_upd;
  logic [31:0] data_upd;
  logic        shifted;
  logic        captured;
  logic [31:0] rv;

  assign dec_adr = (item.opcode == OP_READ_END) ? previous_address : item.bus_address;

  jmbaf_decode u_decode (
    .blk_map (blk_map),
    .adr     (dec_adr),
    .dec     (dec)
  );

  always_comb begin
    blk      = blk_map[dec.idx];
    am       = addr_mask(blk.aw);
    dm       = data_mask(blk.dw);
    a_word   = 24'(item.bus_address >> blk.sh);
    addr_upd = (frame_address & ~am) | (a_word & am);
    data_upd = (frame_data & ~dm) | (item.write_value & dm);

    instr_next   = frame_instr;
    block_next   = frame_block;
    address_next = frame_address;
    data_next    = frame_data;
    prev_next    = previous_address;
    shifted      = 1'b0;
    captured     = 1'b0;
    rv           = 32'd0;

    case (item.opcode)
      OP_READ_START: begin
        prev_next = item.bus_address;
        if (dec.hit) begin
          block_next   = dec.idx;
          address_next = addr_upd;
          instr_next   = INSTR_READ;
          shifted      = 1'b1;
        end
      end
      OP_READ_NEXT: begin
        prev_next = item.bus_address;
        if (dec.hit) begin
          block_next   = dec.idx;
          address_next = addr_upd;
          shifted      = 1'b1;
          captured     = 1'b1;
          rv           = item.captured_bits & dm;
        end
      end
      OP_READ_END: begin
        if (dec.hit) begin
          instr_next = INSTR_IDLE;
          shifted    = 1'b1;
          captured   = 1'b1;
          rv         = item.captured_bits & dm;
        end
      end
      OP_WRITE: begin
        if (dec.hit) begin
          prev_next    = item.bus_address;
          block_next   = dec.idx;
          address_next = addr_upd;
          data_next    = data_upd;
          instr_next   = INSTR_WRITE;
          shifted      = 1'b1;
        end
      end
      default: begin
        shifted = 1'b0;
      end
    endcase

    res.hit           = dec.hit;
    res.shift_done    = shifted;
    res.capture_out   = captured;
    res.instr_field   = instr_next;
    res.block_field   = block_next;
    res.address_field = address_next;
    res.data_field    = data_next;
    res.read_value    = rv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_instr      <= INSTR_IDLE;
      frame_block      <= 2'd0;
      frame_address    <= 24'd0;
      frame_data       <= 32'd0;
      previous_address <= 32'd0;
    end else if (fire) begin
      frame_instr      <= instr_next;
      frame_block      <= block_next;
      frame_address    <= address_next;
      frame_data       <= data_next;
      previous_address <= prev_next;
    end
  end

endmodule

// File: src/jtag_memory_block_access_framer_top.sv
// An accepted transaction waits in the input register, then moves through decode into the result register.
// Throughput: one transaction per cycle unless in_stall is high; frame state feeds back within decode.
// After any configuration write the input stalls while the map is rebuilt
// (three steps per block, four blocks, one 32-bit add per step).
// Reset (rst, synchronous, active high) clears the configuration registers, the frame and both valids.
// ----------------------------------------------------------------------------
// jtag_memory_block_access_framer_top
// Decodes bus transactions onto a memory block scan frame. The map builder
// lays out block address ranges from the width registers; the input register
// feeds decode and frame update, which write a result register that holds
// under stall while the next transaction is taken.
// ----------------------------------------------------------------------------
module jtag_memory_block_access_framer_top import jmbaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] bus_address,
  input  logic [31:0] write_value,
  input  logic [31:0] captured_bits,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        shift_done,
  output logic        capture_out,
  output logic [2:0]  instr_field,
  output logic [1:0]  block_field,
  output logic [23:0] address_field,
  output logic [31:0] data_field,
  output logic [31:0] read_value
);

  map_t  blk_map;
  logic  map_busy;
  logic  s1_valid;
  item_t s1_item;
  res_t  res;
  res_t  out_res;
  logic  s2_take;
  logic  fire;
  logic  in_accept;

  // Registers are always writable; a write restarts the map build.
  assign cfg_ready = 1'b1;

  jmbaf_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_map   (blk_map),
    .busy      (map_busy)
  );

  // Result register takes a new transaction when empty or being drained.
  assign s2_take   = !out_valid || !out_stall;
  assign fire      = s1_valid && s2_take;
  assign in_stall  = map_busy || (s1_valid && !s2_take);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.opcode        <= op_t'(opcode);
      s1_item.bus_address   <= bus_address;
      s1_item.write_value   <= write_value;
      s1_item.captured_bits <= captured_bits;
    end
  end

  // Frame state advances only when the transaction moves to the result register.
  jmbaf_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (s1_item),
    .blk_map (blk_map),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign hit           = out_res.hit;
  assign shift_done    = out_res.shift_done;
  assign capture_out   = out_res.capture_out;
  assign instr_field   = out_res.instr_field;
  assign block_field   = out_res.block_field;
  assign address_field = out_res.address_field;
  assign data_field    = out_res.data_field;
  assign read_value    = out_res.read_value;

endmodule

// File: src/jmbaf_checker.sv
// ----------------------------------------------------------------------------
// jmbaf_checker
// Port-level checks on the framer result channel.
// ----------------------------------------------------------------------------
`include "jtag_memory_block_access_framer_top_defines.svh"

module jmbaf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic        shift_done,
  input logic        capture_out,
  input logic [31:0] read_value
);

  `JMBAF_ASSERT_IMP(a_shift_iff_hit, clk, rst, out_valid, shift_done == hit, "shift without hit")
  `JMBAF_ASSERT_IMP(a_capture_needs_shift, clk, rst, out_valid && capture_out, shift_done, "capture without shift")
  `JMBAF_ASSERT_IMP(a_no_data_on_miss, clk, rst, out_valid && !capture_out, read_value == 32'd0, "read data without capture")
  `JMBAF_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && out_stall, out_valid && $stable(read_value), "stalled result changed")
  `JMBAF_ASSERT_IMP(a_empty_after_reset, clk, rst, $past(rst), !out_valid, "result valid after reset")

endmodule

bind jtag_memory_block_access_framer_top jmbaf_checker u_jmbaf_checker (.*);

// File: verif/jmbaf_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmbaf_access_checker
// Watches the register, access and frame channels of the scan framer, keeps
// its own copy of the block map and frame, and checks every frame result.
// ----------------------------------------------------------------------------
module jmbaf_access_checker import jmbaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] bus_address,
  input  logic [31:0] write_value,
  input  logic [31:0] captured_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic        shift_done,
  input  logic        capture_out,
  input  logic [2:0]  instr_field,
  input  logic [1:0]  block_field,
  input  logic [23:0] address_field,
  input  logic [31:0] data_field,
  input  logic [31:0] read_value,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    bit          ok;
    bit [4:0]    aw;
    bit [5:0]    dw;
    int unsigned sh;
    bit [31:0]   base;
    bit [31:0]   last;
  } region_t;

  bit [4:0]  width_addr [4];
  bit [5:0]  width_data [4];
  region_t   rg [4];

  bit [2:0]  f_instr;
  bit [1:0]  f_block;
  bit [23:0] f_addr;
  bit [31:0] f_data;
  bit [31:0] last_adr;

  res_t      frames_due [$];

  function automatic bit [31:0] width_mask(input int unsigned w, input int unsigned cap);
    bit [32:0] m;
    if (w > cap) w = cap;
    m = (33'd1 << w) - 33'd1;
    return m[31:0];
  endfunction

  // Address map from the width registers; sums wrap at 32 bits.
  function automatic void lay_out_regions();
    int          i;
    int          prev;
    int unsigned nb;
    bit [63:0]   sz64;
    bit [31:0]   sz;
    bit [31:0]   psz;
    prev = -1;
    for (i = 0; i < 4; i++) begin
      rg[i].ok = 1'b0;
      if (width_addr[i] != 0 && width_data[i] != 0) begin
        rg[i].ok = 1'b1;
        rg[i].aw = width_addr[i];
        rg[i].dw = width_data[i];
        nb = (int'(width_data[i]) + 7) / 8;
        rg[i].sh = 0;
        while (nb > 1) begin
          rg[i].sh++;
          nb >>= 1;
        end
        sz64 = 64'd1 << (rg[i].aw + rg[i].sh);
        sz = sz64[31:0];
        if (prev < 0) begin
          rg[i].base = '0;
        end else if ((32'(rg[i].aw) << rg[i].sh) <= (32'(rg[prev].aw) << rg[prev].sh)) begin
          sz64 = 64'd1 << (rg[prev].aw + rg[prev].sh);
          psz = sz64[31:0];
          rg[i].base = rg[prev].base + psz;
        end else begin
          rg[i].base = (rg[prev].base & ~(sz - 32'd1)) + sz;
        end
        rg[i].last = rg[i].base + sz - 32'd1;
        prev = i;
      end
    end
  endfunction

  // Highest block first, with a running bound; -1 is a miss.
  function automatic int find_region(input bit [31:0] adr);
    int        i;
    int        sel;
    bit [31:0] bound;
    sel = -1;
    bound = '0;
    for (i = 3; i >= 0; i--) begin
      if (rg[i].ok) begin
        if (rg[i].base <= adr && rg[i].last >= adr) begin
          sel = i;
          bound = rg[i].base;
        end else if ((bound > adr || bound == 0) && rg[i].last < adr) begin
          sel = -1;
          bound = rg[i].last + 32'd1;
        end else begin
          bound = rg[i].base;
        end
      end
    end
    return sel;
  endfunction

  function automatic res_t frame_after_access(input op_t op, input bit [31:0] adr,
                                              input bit [31:0] wv, input bit [31:0] cap);
    res_t      r;
    int        idx;
    bit [31:0] am;
    bit [31:0] dm;
    bit [31:0] a_sh;
    r = '0;
    lay_out_regions();
    if (op == OP_READ_END) begin
      idx = find_region(last_adr);
      if (idx >= 0) begin
        r.hit = 1'b1;
        r.shift_done = 1'b1;
        r.capture_out = 1'b1;
        f_instr = INSTR_IDLE;
        r.read_value = cap & width_mask(rg[idx].dw, 32);
      end
    end else begin
      idx = find_region(adr);
      if (idx < 0) begin
        if (op != OP_WRITE) last_adr = adr;
      end else begin
        r.hit = 1'b1;
        r.shift_done = 1'b1;
        last_adr = adr;
        f_block = idx[1:0];
        am = width_mask(rg[idx].aw, 24);
        a_sh = adr >> rg[idx].sh;
        f_addr = (f_addr & ~am[23:0]) | (a_sh[23:0] & am[23:0]);
        case (op)
          OP_READ_START: f_instr = INSTR_READ;
          OP_READ_NEXT: begin
            r.capture_out = 1'b1;
            r.read_value = cap & width_mask(rg[idx].dw, 32);
          end
          default: begin
            dm = width_mask(rg[idx].dw, 32);
            f_data = (f_data & ~dm) | (wv & dm);
            f_instr = INSTR_WRITE;
          end
        endcase
      end
    end
    r.instr_field = f_instr;
    r.block_field = f_block;
    r.address_field = f_addr;
    r.data_field = f_data;
    return r;
  endfunction

  function automatic string show_frame(input res_t r);
    return $sformatf("hit=%0b shift=%0b cap=%0b instr=%0d blk=%0d addr=%h data=%h rd=%h",
                     r.hit, r.shift_done, r.capture_out, r.instr_field, r.block_field,
                     r.address_field, r.data_field, r.read_value);
  endfunction

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst) begin
      width_addr = '{default: '0};
      width_data = '{default: '0};
      f_instr = '0;
      f_block = '0;
      f_addr = '0;
      f_data = '0;
      last_adr = '0;
      frames_due.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // frame result side first: it always belongs to an older access
      if (out_valid && !out_stall) begin
        seen.hit = hit;
        seen.shift_done = shift_done;
        seen.capture_out = capture_out;
        seen.instr_field = instr_field;
        seen.block_field = block_field;
        seen.address_field = address_field;
        seen.data_field = data_field;
        seen.read_value = read_value;
        if (frames_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected frame result: %s", $realtime, show_frame(seen));
        end else begin
          want = frames_due.pop_front();
          checked++;
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] frame mismatch, expected %s", $realtime, show_frame(want));
              $display("[%0t]                 actual   %s", $realtime, show_frame(seen));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < CFG_DATA_BASE) width_addr[cfg_index] = cfg_data[4:0];
        else width_data[cfg_index - CFG_DATA_BASE] = cfg_data;
      end
      if (in_valid && !in_stall)
        frames_due.push_back(frame_after_access(op_t'(opcode), bus_address,
                                                write_value, captured_bits));
    end
    pending = frames_due.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the memory block scan framer: programs a series of block
// maps, sends directed then random bus access transactions in bursts, and
// applies receiver back-pressure; the checker module judges each frame.
// ----------------------------------------------------------------------------
module tb_top;
  import jmbaf_pkg::*;

  localparam int          LIMIT_CYCLES       = 400000;
  localparam int          HOLD_CYCLES        = 90;   // long receiver hold-off
  localparam int          DRAIN_CYCLES       = 8;    // settling margin after the last frame returns
  localparam logic [2:0]  REG_ADDR_BITS_BASE = 3'd0; // addr_bits_zero..three
  // data_bits_zero..three start at CFG_DATA_BASE from the package

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [31:0] bus_address;
  logic [31:0] write_value;
  logic [31:0] captured_bits;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic        shift_done;
  logic        capture_out;
  logic [2:0]  instr_field;
  logic [1:0]  block_field;
  logic [23:0] address_field;
  logic [31:0] data_field;
  logic [31:0] read_value;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  int cur_aw [4];
  int cur_dw [4];
  int n_sent;
  int n_maps;
  int burst_left;
  bit gapless;
  int stall_mode;
  int hold_requests;
  int holds_done;
  int hold_left;
  int rx_tick;
  int cycles;

  jtag_memory_block_access_framer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .bus_address   (bus_address),
    .write_value   (write_value),
    .captured_bits (captured_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .shift_done    (shift_done),
    .capture_out   (capture_out),
    .instr_field   (instr_field),
    .block_field   (block_field),
    .address_field (address_field),
    .data_field    (data_field),
    .read_value    (read_value)
  );

  jmbaf_access_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .bus_address   (bus_address),
    .write_value   (write_value),
    .captured_bits (captured_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .shift_done    (shift_done),
    .capture_out   (capture_out),
    .instr_field   (instr_field),
    .block_field   (block_field),
    .address_field (address_field),
    .data_field    (data_field),
    .read_value    (read_value),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d frames still due", cycles, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall pattern picked by stall_mode, plus a long hold-off on
  // request, counted here so the sender keeps offering while the frame side
  // is blocked and the block has to stall its input.
  initial begin
    holds_done = 0;
    hold_left = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ((rx_tick % 7) < 3);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Sender pacing: bursts of random length with idle gaps between them.
  task automatic pace();
    int gap;
    if (gapless) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // One access transaction; valid stays up so the next one can follow
  // back to back.
  task automatic access(input op_t op, input logic [31:0] a,
                        input logic [31:0] wv, input logic [31:0] cap);
    @(negedge clk);
    in_valid      <= 1'b1;
    opcode        <= op;
    bus_address   <= a;
    write_value   <= wv;
    captured_bits <= cap;
    do @(posedge clk); while (in_stall);
    n_sent++;
    pace();
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[5:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Register writes only with the block idle: every frame back, plus a settling margin.
  task automatic program_map(input int a0, input int a1, input int a2, input int a3,
                             input int d0, input int d1, input int d2, input int d3);
    int i;
    @(negedge clk) in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cur_aw = '{a0, a1, a2, a3};
    cur_dw = '{d0, d1, d2, d3};
    for (i = 0; i < 4; i++) write_reg(REG_ADDR_BITS_BASE + 3'(i), cur_aw[i]);
    for (i = 0; i < 4; i++) write_reg(CFG_DATA_BASE + 3'(i), cur_dw[i]);
    @(negedge clk) cfg_valid <= 1'b0;
    n_maps++;
  endtask

  function automatic int rand_aw();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(9, 24);
    return $urandom_range(1, 8);
  endfunction

  function automatic int rand_dw();
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
  endfunction

  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Mostly addresses inside a rough span of the current map, so that most
  // accesses hit; the rest are values around bit boundaries, extremes and wild values.
  function automatic logic [31:0] pick_address();
    longint span;
    int     sel;
    int     i;
    span = 16;
    for (i = 0; i < 4; i++)
      if (cur_aw[i] != 0 && cur_dw[i] != 0) span += longint'(1) << (cur_aw[i] + 3);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(0, 32'(span));
    if (sel == 7) return $urandom();
    if (sel == 8) return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
    return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  // Random traffic: mostly read bursts (start, next..., end) and write runs
  // with random content; the rest is loose opcodes and broken bursts.
  task automatic run_random(input int count);
    int          first;
    int          kind;
    int          k;
    logic [31:0] a;
    logic [31:0] step;
    first = n_sent;
    while (n_sent - first < count) begin
      kind = $urandom_range(0, 9);
      a = pick_address();
      step = 32'd1 << $urandom_range(0, 2);
      if (kind < 5) begin
        access(OP_READ_START, a, rand_word(), rand_word());
        k = $urandom_range(0, 6);
        repeat (k) begin
          a += step;
          access(OP_READ_NEXT, a, rand_word(), rand_word());
        end
        // sometimes the burst is left open
        if ($urandom_range(0, 5) != 0) access(OP_READ_END, rand_word(), rand_word(), rand_word());
      end else if (kind < 8) begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          access(OP_WRITE, a, rand_word(), rand_word());
          a += step;
        end
      end else begin
        access(op_t'($urandom_range(0, 3)), a, rand_word(), rand_word());
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = '0;
    bus_address = '0;
    write_value = '0;
    captured_bits = '0;
    out_stall = 1'b0;
    cur_aw = '{default: 0};
    cur_dw = '{default: 0};
    n_sent = 0;
    n_maps = 0;
    burst_left = 0;
    gapless = 1'b0;
    stall_mode = 0;
    hold_requests = 0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // --- directed ----------------------------------------------------------
    // Reset map: every block absent, so every transaction misses.
    access(OP_READ_START, 32'h10, 32'h0, 32'hFFFF_FFFF);
    access(OP_WRITE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    access(OP_READ_END, 32'h0, 32'h0, 32'hFFFF_FFFF);

    // Map: blk0 0..15, blk1 16..31 (aligned up), blk2 256..511, blk3 512..519.
    program_map(4, 3, 6, 2, 8, 16, 32, 24);
    access(OP_READ_START, 32'h0, 32'h0, 32'hFFFF_FFFF);
    access(OP_READ_NEXT, 32'h5, 32'h0, 32'hFFFF_FFFF);
    access(OP_READ_NEXT, 32'd20, 32'h0, 32'hFFFF_FFFF);
    // read end decodes the stored address, not the one on the bus
    access(OP_READ_END, 32'hFFFF_FFFF, 32'h0, 32'hA5A5_5A5A);
    access(OP_WRITE, 32'd300, 32'hFFFF_FFFF, 32'h0);
    // narrow data width: the upper data field bits must survive
    access(OP_WRITE, 32'd516, 32'h0, 32'h0);
    access(OP_READ_NEXT, 32'h100, 32'h0, 32'hFFFF_FFFF);
    // gap between blocks: miss still records the address
    access(OP_READ_START, 32'd100, 32'h0, 32'hFFFF_FFFF);
    access(OP_READ_END, 32'd4, 32'h0, 32'hFFFF_FFFF);
    access(OP_READ_NEXT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    access(OP_WRITE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0);
    access(OP_READ_START, 32'd519, 32'h0, 32'h0);
    access(OP_READ_END, 32'h0, 32'h0, 32'hFFFF_FFFF);
    stall_mode = 1;
    run_random(60);

    // Widest widths: full 24-bit address mask and 32-bit data mask.
    program_map(24, 24, 1, 1, 32, 1, 32, 1);
    stall_mode = 0;
    access(OP_WRITE, 32'h03FF_FFFC, 32'hFFFF_FFFF, 32'h0);
    access(OP_READ_START, 32'h04FF_FFFF, 32'h0, 32'hFFFF_FFFF);
    access(OP_READ_NEXT, 32'h0500_0000, 32'h0, 32'hFFFF_FFFF);
    access(OP_READ_END, 32'h0, 32'h0, 32'hFFFF_FFFF);
    access(OP_WRITE, 32'h0500_0004, 32'h0, 32'hFFFF_FFFF);

    // --- random ------------------------------------------------------------
    // Back-pressure: receiver holds off for a long stretch while the sender
    // streams with no gaps.
    stall_mode = 2;
    gapless = 1'b1;
    hold_requests++;
    run_random(60);
    gapless = 1'b0;

    // Some blocks absent (zero address width, zero data width).
    program_map(0, 5, 1, 24, 7, 0, 9, 17);
    stall_mode = 0;
    run_random(50);

    // Smallest address widths with assorted data widths.
    program_map(1, 1, 1, 1, 1, 8, 9, 32);
    stall_mode = 3;
    run_random(50);

    repeat (5) begin
      program_map(rand_aw(), rand_aw(), rand_aw(), rand_aw(),
                  rand_dw(), rand_dw(), rand_dw(), rand_dw());
      stall_mode = $urandom_range(0, 3);
      gapless = ($urandom_range(0, 3) == 0);
      run_random(45);
    end
    gapless = 1'b0;

    // --- drain and verdict ---------------------------------------------------
    @(negedge clk) in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d access transactions over %0d block maps; %0d frames checked.",
             n_sent, n_maps, checked);
    $display("Traffic mixed read bursts, writes and misses under bursty send and stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
